// ===== hw/rtl/gbb_pkg.sv =====
// ----------------------------------------------------------------------------
// Glyph bitmap blitter package
// Shared widths, codes and the structs that travel between the front end,
// the job queue and the pixel back end.
// ----------------------------------------------------------------------------
`default_nettype none

package gbb_pkg;

    // Field widths.
    localparam int COORD_BITS = 12;
    localparam int DIM_BITS   = 8;
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_BITS = 2;
    localparam int CFG_INDEX_BITS = 3;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_BITS-1:0] CFG_FRAME_BASE  = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_LINE_BYTES  = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_PIXEL_FMT   = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_FOREGROUND  = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_BACKGROUND  = 3'd4;

    // Framebuffer pixel formats.
    localparam logic [1:0] PIX_8BPP   = 2'd0;
    localparam logic [1:0] PIX_RGB565 = 2'd1;
    localparam logic [1:0] PIX_32BPP  = 2'd2;
    localparam logic [1:0] PIX_BAD    = 2'd3;

    // Item kinds.
    localparam logic MODE_START = 1'b0;
    localparam logic MODE_DATA  = 1'b1;

    // Register reset values.
    localparam logic [23:0] FG_RESET = 24'hffffff;

    typedef struct packed {
        logic [31:0] frame_base;
        logic [15:0] line_bytes;
        logic [1:0]  pixel_format;
        logic [23:0] foreground;
        logic [23:0] background;
    } t_cfg;

    typedef struct packed {
        logic                  mode;
        logic [COORD_BITS-1:0] x_left;
        logic [COORD_BITS-1:0] y_top;
        logic [DIM_BITS-1:0]   glyph_width;
        logic [DIM_BITS-1:0]   glyph_height;
        logic [DIM_BITS-1:0]   row_pitch;
        logic                  glyph_eight_bit;
        logic [7:0]            data_byte;
    } t_item;

    // One queued job: up to eight pixels on one glyph row, or one error.
    typedef struct packed {
        logic                  err;
        logic                  use_bg;
        logic [7:0]            mask;
        logic [COORD_BITS-1:0] col0;
        logic [31:0]           row_addr;
    } t_job;

    typedef struct packed {
        logic [31:0] write_address;
        logic [31:0] write_data;
        logic [2:0]  write_bytes;
        logic        error;
        logic        last;
    } t_result;

endpackage

`default_nettype wire

// ===== hw/rtl/gbb_front.sv =====
// ----------------------------------------------------------------------------
// Glyph blitter front end
// Tracks the glyph cursor, turns each pixel-writing byte into one job with a
// column mask and a precomputed row address, and ends glyphs on error.
// ----------------------------------------------------------------------------
`default_nettype none

module gbb_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_accept,
    input  wire gbb_pkg::t_item i_item,
    input  wire gbb_pkg::t_cfg  i_cfg,
    output logic               o_push,
    output gbb_pkg::t_job      o_job
);

    localparam int CW = gbb_pkg::COORD_BITS;
    localparam int DW = gbb_pkg::DIM_BITS;

    logic [CW-1:0] r_glyph_left, n_glyph_left;
    logic [CW-1:0] r_cursor_x, n_cursor_x;
    logic [CW-1:0] r_cursor_y, n_cursor_y;
    logic [DW-1:0] r_width, n_width;
    logic [DW-1:0] r_rows, n_rows;
    logic [DW-1:0] r_pitch, n_pitch;
    logic [DW-1:0] r_bir, n_bir;
    logic          r_fmt, n_fmt;
    logic          r_active, n_active;

    logic [DW:0]     w_row_bytes;
    logic [DW:0]     w_span;
    logic [DW-1:0]   w_bir_inc;
    logic [DW+2:0]   w_first;
    logic [DW+2:0]   w_first8;
    logic [DW+2:0]   w_width_ext;
    logic [DW+2:0]   w_cols_left;
    logic [DW+2:0]   w_stop;
    logic            w_in_row;
    logic [7:0]      w_mask;
    logic [7:0]      w_bits;
    logic [CW+15:0]  w_row_off;
    logic            w_bad_fmt;
    logic            w_end_row;
    logic [DW-1:0]   w_rows_dec;

    // Row geometry of a one-bit glyph.
    assign w_row_bytes = ({1'b0, r_width} + (DW+1)'(7)) >> 3;
    assign w_span      = ({1'b0, r_pitch} > w_row_bytes) ? {1'b0, r_pitch} : w_row_bytes;
    assign w_bir_inc   = r_bir + DW'(1);
    assign w_in_row    = {1'b0, r_bir} < w_row_bytes;
    assign w_first     = {r_bir, 3'b000};
    assign w_first8    = w_first + (DW+3)'(8);
    assign w_width_ext = (DW+3)'(r_width);
    assign w_cols_left = w_width_ext - w_first;
    assign w_stop      = (w_first8 > w_width_ext) ? w_width_ext : w_first8;

    // Columns of this byte that fall inside the glyph, MSB first.
    assign w_mask = (w_cols_left >= (DW+3)'(8)) ? 8'hff : ~(8'hff >> w_cols_left[2:0]);
    assign w_bits = i_item.data_byte & w_mask;

    // Framebuffer row offset of the current glyph row.
    assign w_row_off  = (CW+16)'(r_cursor_y) * (CW+16)'(i_cfg.line_bytes);
    assign w_bad_fmt  = i_cfg.pixel_format == gbb_pkg::PIX_BAD;
    assign w_rows_dec = r_rows - DW'(1);

    // Next glyph state and the job for this beat.
    always_comb begin
        n_glyph_left = r_glyph_left;
        n_cursor_x   = r_cursor_x;
        n_cursor_y   = r_cursor_y;
        n_width      = r_width;
        n_rows       = r_rows;
        n_pitch      = r_pitch;
        n_bir        = r_bir;
        n_fmt        = r_fmt;
        n_active     = r_active;
        w_end_row    = 1'b0;
        o_push       = 1'b0;
        o_job.err      = 1'b0;
        o_job.use_bg   = 1'b0;
        o_job.mask     = 8'h80;
        o_job.col0     = r_cursor_x;
        o_job.row_addr = i_cfg.frame_base + 32'(w_row_off);

        if (i_accept) begin
            if (i_item.mode == gbb_pkg::MODE_START) begin
                n_glyph_left = i_item.x_left;
                n_cursor_x   = i_item.x_left;
                n_cursor_y   = i_item.y_top;
                n_width      = i_item.glyph_width;
                n_rows       = i_item.glyph_height;
                n_pitch      = i_item.row_pitch;
                n_fmt        = i_item.glyph_eight_bit;
                n_bir        = '0;
                n_active     = (i_item.glyph_width != '0) && (i_item.glyph_height != '0);
            end else if (r_active) begin
                if (r_fmt) begin
                    // Eight-bit glyph: one pixel per byte.
                    o_push = 1'b1;
                    if (w_bad_fmt) begin
                        o_job.err = 1'b1;
                        n_active  = 1'b0;
                    end else begin
                        o_job.use_bg = (i_item.data_byte == 8'h00);
                        n_bir        = w_bir_inc;
                        n_cursor_x   = r_cursor_x + CW'(1);
                        w_end_row    = w_bir_inc >= r_width;
                    end
                end else if (w_in_row && (w_bits != 8'h00) && w_bad_fmt) begin
                    // One-bit byte that would write a pixel on a bad depth.
                    o_push    = 1'b1;
                    o_job.err = 1'b1;
                    n_active  = 1'b0;
                end else begin
                    if (w_in_row) begin
                        o_push     = w_bits != 8'h00;
                        o_job.mask = w_bits;
                        o_job.col0 = r_glyph_left + CW'(w_first);
                        n_cursor_x = r_glyph_left + CW'(w_stop);
                    end
                    n_bir     = w_bir_inc;
                    w_end_row = {1'b0, w_bir_inc} >= w_span;
                end
                if (w_end_row) begin
                    n_bir      = '0;
                    n_cursor_x = r_glyph_left;
                    n_cursor_y = r_cursor_y + CW'(1);
                    n_rows     = w_rows_dec;
                    n_active   = w_rows_dec != '0;
                end
            end
        end
    end

    // Glyph state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_glyph_left <= '0;
            r_cursor_x   <= '0;
            r_cursor_y   <= '0;
            r_width      <= '0;
            r_rows       <= '0;
            r_pitch      <= '0;
            r_bir        <= '0;
            r_fmt        <= 1'b0;
            r_active     <= 1'b0;
        end else begin
            r_glyph_left <= n_glyph_left;
            r_cursor_x   <= n_cursor_x;
            r_cursor_y   <= n_cursor_y;
            r_width      <= n_width;
            r_rows       <= n_rows;
            r_pitch      <= n_pitch;
            r_bir        <= n_bir;
            r_fmt        <= n_fmt;
            r_active     <= n_active;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/gbb_queue.sv =====
// ----------------------------------------------------------------------------
// Glyph blitter job queue
// Small FIFO of pixel jobs between the front end and the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module gbb_queue (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire gbb_pkg::t_job  i_job,
    input  wire logic          i_pop,
    output logic               o_full,
    output logic               o_nonempty,
    output gbb_pkg::t_job      o_head
);

    localparam int PW = gbb_pkg::QUEUE_PTR_BITS;
    localparam int DEPTH = gbb_pkg::QUEUE_DEPTH;

    gbb_pkg::t_job r_mem [DEPTH];
    logic [PW-1:0] r_wr_ptr, n_wr_ptr;
    logic [PW-1:0] r_rd_ptr, n_rd_ptr;
    logic [PW:0]   r_count, n_count;

    assign o_full     = r_count == (PW+1)'(DEPTH);
    assign o_nonempty = r_count != '0;
    assign o_head     = r_mem[r_rd_ptr];

    // Pointer and fill count update.
    always_comb begin
        n_wr_ptr = i_push ? r_wr_ptr + PW'(1) : r_wr_ptr;
        n_rd_ptr = i_pop  ? r_rd_ptr + PW'(1) : r_rd_ptr;
        n_count  = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + (PW+1)'(1);
        end else if (!i_push && i_pop) begin
            n_count = r_count - (PW+1)'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/gbb_back.sv =====
// ----------------------------------------------------------------------------
// Glyph blitter back end
// Walks the set bits of the head job one per cycle unless the output stalls,
// packs the color and forms the pixel address into a registered output beat.
// ----------------------------------------------------------------------------
`default_nettype none

module gbb_back (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire gbb_pkg::t_cfg  i_cfg,
    input  wire logic          i_head_valid,
    input  wire gbb_pkg::t_job  i_head,
    output logic               o_pop,
    input  wire logic          i_stall,
    output logic               o_valid,
    output gbb_pkg::t_result   o_result
);

    localparam int CW = gbb_pkg::COORD_BITS;

    logic             r_loaded, n_loaded;
    logic [7:0]       r_rem, n_rem;
    logic             r_out_valid, n_out_valid;
    gbb_pkg::t_result r_out, n_out;

    logic [7:0]    w_rem;
    logic [2:0]    w_k;
    logic [7:0]    w_new_rem;
    logic          w_emit;
    logic [CW-1:0] w_col;
    logic [23:0]   w_color;
    logic [1:0]    w_shift;
    logic [2:0]    w_size;
    logic [31:0]   w_data;
    logic [31:0]   w_col_off;

    assign w_rem  = r_loaded ? r_rem : i_head.mask;
    assign w_emit = i_head_valid && (!r_out_valid || !i_stall);

    // Leftmost remaining pixel of the job.
    always_comb begin
        w_k = 3'd0;
        for (int i = 7; i >= 0; i--) begin
            if (w_rem[7-i]) begin
                w_k = 3'(i);
            end
        end
    end

    assign w_new_rem = w_rem & ~(8'h80 >> w_k);
    assign w_col     = i_head.col0 + CW'(w_k);
    assign w_color   = i_head.use_bg ? i_cfg.background : i_cfg.foreground;

    // Pixel packing for the framebuffer depth.
    always_comb begin
        unique case (i_cfg.pixel_format)
            gbb_pkg::PIX_8BPP: begin
                w_shift = 2'd0;
                w_size  = 3'd1;
                w_data  = {24'h0, w_color[7:0]};
            end
            gbb_pkg::PIX_RGB565: begin
                w_shift = 2'd1;
                w_size  = 3'd2;
                w_data  = {16'h0, w_color[23:19], w_color[15:10], w_color[7:3]};
            end
            gbb_pkg::PIX_32BPP: begin
                w_shift = 2'd2;
                w_size  = 3'd4;
                w_data  = {8'h0, w_color};
            end
            default: begin
                w_shift = 2'd0;
                w_size  = 3'd0;
                w_data  = 32'h0;
            end
        endcase
    end

    assign w_col_off = 32'(w_col) << w_shift;

    // Next output beat and job progress.
    always_comb begin
        o_pop       = 1'b0;
        n_loaded    = r_loaded;
        n_rem       = r_rem;
        n_out       = r_out;
        n_out_valid = r_out_valid && i_stall;
        if (w_emit) begin
            n_out_valid = 1'b1;
            if (i_head.err) begin
                n_out.write_address = 32'h0;
                n_out.write_data    = 32'h0;
                n_out.write_bytes   = 3'd0;
                n_out.error         = 1'b1;
                n_out.last          = 1'b1;
                o_pop               = 1'b1;
                n_loaded            = 1'b0;
            end else begin
                n_out.write_address = i_head.row_addr + w_col_off;
                n_out.write_data    = w_data;
                n_out.write_bytes   = w_size;
                n_out.error         = 1'b0;
                n_out.last          = w_new_rem == 8'h00;
                o_pop               = w_new_rem == 8'h00;
                n_loaded            = w_new_rem != 8'h00;
                n_rem               = w_new_rem;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_loaded    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_loaded    <= n_loaded;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_out <= n_out;
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_out;

endmodule

`default_nettype wire

// ===== hw/rtl/glyph_bitmap_blitter.sv =====
// ----------------------------------------------------------------------------
// Glyph bitmap blitter
// Draws font glyphs into a framebuffer as a stream of pixel writes.
// ----------------------------------------------------------------------------
// A start beat (i_mode low) latches glyph position, size, pitch and format;
// data beats then carry the bitmap bytes. Each output beat is one pixel
// write (address, packed data, byte count) or one error beat when the
// framebuffer depth is unsupported; o_last marks the final write of a byte.
// Input beats are taken while o_stall is low; o_stall rises only when the
// four-entry job queue is full. Output beats are held in a register until
// taken while i_stall is low, and the input side keeps flowing meanwhile.
// A byte's writes pass through the job queue and the output register. Pixel
// writes issue one per cycle unless the output stalls: one per set pixel of
// a one-bit byte (up to eight), one per eight-bit byte; start beats and
// bytes that write nothing queue no job. Configuration registers are written
// through i_cfg_we, i_cfg_index and i_cfg_data; the user must do so only
// while the block is idle, which it does not enforce. Reset clears the glyph
// state, empties the queue and output register and loads the register reset values.
// ----------------------------------------------------------------------------
`default_nettype none

module glyph_bitmap_blitter (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // Configuration port
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [31:0] i_cfg_data,
    // Input channel
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic        i_mode,
    input  wire logic [11:0] i_x_left,
    input  wire logic [11:0] i_y_top,
    input  wire logic [7:0]  i_glyph_width,
    input  wire logic [7:0]  i_glyph_height,
    input  wire logic [7:0]  i_row_pitch,
    input  wire logic        i_glyph_eight_bit,
    input  wire logic [7:0]  i_data_byte,
    // Output channel
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [31:0]      o_write_address,
    output logic [31:0]      o_write_data,
    output logic [2:0]       o_write_bytes,
    output logic             o_error,
    output logic             o_last
);

    gbb_pkg::t_cfg    r_cfg;
    gbb_pkg::t_item   w_item;
    gbb_pkg::t_job    w_job;
    gbb_pkg::t_job    w_head;
    gbb_pkg::t_result w_result;
    logic             w_accept;
    logic             w_push;
    logic             w_pop;
    logic             w_full;
    logic             w_nonempty;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.frame_base   <= 32'h0;
            r_cfg.line_bytes   <= 16'h0;
            r_cfg.pixel_format <= gbb_pkg::PIX_32BPP;
            r_cfg.foreground   <= gbb_pkg::FG_RESET;
            r_cfg.background   <= 24'h0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                gbb_pkg::CFG_FRAME_BASE: r_cfg.frame_base   <= i_cfg_data;
                gbb_pkg::CFG_LINE_BYTES: r_cfg.line_bytes   <= i_cfg_data[15:0];
                gbb_pkg::CFG_PIXEL_FMT:  r_cfg.pixel_format <= i_cfg_data[1:0];
                gbb_pkg::CFG_FOREGROUND: r_cfg.foreground   <= i_cfg_data[23:0];
                gbb_pkg::CFG_BACKGROUND: r_cfg.background   <= i_cfg_data[23:0];
                default: ;
            endcase
        end
    end

    // Input beat handshake and payload.
    assign o_stall  = w_full;
    assign w_accept = i_valid && !w_full;

    assign w_item.mode            = i_mode;
    assign w_item.x_left          = i_x_left;
    assign w_item.y_top           = i_y_top;
    assign w_item.glyph_width     = i_glyph_width;
    assign w_item.glyph_height    = i_glyph_height;
    assign w_item.row_pitch       = i_row_pitch;
    assign w_item.glyph_eight_bit = i_glyph_eight_bit;
    assign w_item.data_byte       = i_data_byte;

    gbb_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (w_accept),
        .i_item   (w_item),
        .i_cfg    (r_cfg),
        .o_push   (w_push),
        .o_job    (w_job)
    );

    gbb_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (w_push),
        .i_job      (w_job),
        .i_pop      (w_pop),
        .o_full     (w_full),
        .o_nonempty (w_nonempty),
        .o_head     (w_head)
    );

    gbb_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_head_valid (w_nonempty),
        .i_head       (w_head),
        .o_pop        (w_pop),
        .i_stall      (i_stall),
        .o_valid      (o_valid),
        .o_result     (w_result)
    );

    // Output beat payload.
    assign o_write_address = w_result.write_address;
    assign o_write_data    = w_result.write_data;
    assign o_write_bytes   = w_result.write_bytes;
    assign o_error         = w_result.error;
    assign o_last          = w_result.last;

endmodule

`default_nettype wire

// ===== test/glyph_bitmap_blitter_tb.sv =====
// ----------------------------------------------------------------------------
// Glyph bitmap blitter testbench
// Feeds start and bitmap beats under random idling and output stalls, and
// checks every pixel write against a scoreboard that redraws each glyph.
// ----------------------------------------------------------------------------
// The scoreboard keeps its own copy of the registers and the glyph cursor.
// Each accepted input beat is turned into the pixel writes it should cause,
// and each output beat is compared field by field with the oldest of them.
// The run has a directed part (wrapping coordinates, padding bytes, short
// pitch, empty glyphs, widest glyph, unsupported depth), then random glyphs
// under five framebuffer setups that cover every pixel format.
// ----------------------------------------------------------------------------

module glyph_bitmap_blitter_tb;

    import gbb_pkg::*;

    // Redraws glyphs from the accepted beats and checks the pixel writes.
    class glyph_scoreboard;
        logic [31:0] frame_base;
        logic [15:0] line_bytes;
        logic [1:0]  pixel_format;
        logic [23:0] fg_color;
        logic [23:0] bg_color;

        logic [11:0] left_col;
        logic [11:0] cur_x;
        logic [11:0] cur_y;
        logic [7:0]  width_q;
        logic [7:0]  rows_left;
        logic [7:0]  pitch_q;
        logic [7:0]  byte_idx;
        logic        eight_bit_q;
        logic        active;

        t_result pending_writes[$];
        int      mismatches;
        int      writes_checked;
        int      errors_seen;

        function new();
            frame_base   = '0;
            line_bytes   = '0;
            pixel_format = PIX_32BPP;
            fg_color     = FG_RESET;
            bg_color     = '0;
            left_col     = '0;
            cur_x        = '0;
            cur_y        = '0;
            width_q      = '0;
            rows_left    = '0;
            pitch_q      = '0;
            byte_idx     = '0;
            eight_bit_q  = 1'b0;
            active       = 1'b0;
            mismatches   = 0;
            writes_checked = 0;
            errors_seen  = 0;
        endfunction

        function void set_reg(input logic [2:0] index, input logic [31:0] value);
            case (index)
                CFG_FRAME_BASE: frame_base   = value;
                CFG_LINE_BYTES: line_bytes   = value[15:0];
                CFG_PIXEL_FMT:  pixel_format = value[1:0];
                CFG_FOREGROUND: fg_color     = value[23:0];
                CFG_BACKGROUND: bg_color     = value[23:0];
                default: ;
            endcase
        endfunction

        // Packs one pixel for the current depth; returns 0 when the depth is unsupported.
        function bit pack_pixel(input logic [11:0] x, input logic [11:0] y,
                                input logic [23:0] color, output t_result w);
            logic [2:0]  nbytes;
            logic [31:0] data;
            w = '0;
            case (pixel_format)
                PIX_8BPP: begin
                    nbytes = 3'd1;
                    data   = {24'b0, color[7:0]};
                end
                PIX_RGB565: begin
                    nbytes = 3'd2;
                    data   = {16'b0, color[23:19], color[15:10], color[7:3]};
                end
                PIX_32BPP: begin
                    nbytes = 3'd4;
                    data   = {8'b0, color};
                end
                default: return 1'b0;
            endcase
            w.write_address = frame_base + 32'(y) * 32'(line_bytes) + 32'(x) * 32'(nbytes);
            w.write_data    = data;
            w.write_bytes   = nbytes;
            return 1'b1;
        endfunction

        // An unsupported depth gives one error beat and drops the glyph.
        function void abandon();
            t_result w;
            w = '0;
            w.error = 1'b1;
            w.last  = 1'b1;
            pending_writes.push_back(w);
            active = 1'b0;
        endfunction

        function void end_row();
            byte_idx  = '0;
            cur_x     = left_col;
            cur_y     = cur_y + 12'd1;
            rows_left = rows_left - 8'd1;
            if (rows_left == 0) begin
                active = 1'b0;
            end
        endfunction

        // Works out the writes caused by one accepted input beat.
        function void note_beat(input t_item it);
            t_result batch[$];
            t_result w;
            int      row_bytes;
            int      span;
            int      first;
            int      stop;
            if (it.mode == MODE_START) begin
                left_col    = it.x_left;
                cur_x       = it.x_left;
                cur_y       = it.y_top;
                width_q     = it.glyph_width;
                rows_left   = it.glyph_height;
                pitch_q     = it.row_pitch;
                eight_bit_q = it.glyph_eight_bit;
                byte_idx    = '0;
                active      = (it.glyph_width != 0) && (it.glyph_height != 0);
                return;
            end
            if (!active) begin
                return;
            end

            if (eight_bit_q) begin
                // One byte is one pixel: foreground if nonzero.
                if (!pack_pixel(cur_x, cur_y, (it.data_byte != 0) ? fg_color : bg_color, w))
                begin
                    abandon();
                    return;
                end
                batch.push_back(w);
                byte_idx = byte_idx + 8'd1;
                cur_x    = cur_x + 12'd1;
                if (byte_idx >= width_q) begin
                    end_row();
                end
            end else begin
                // A row never takes fewer bytes than its width needs.
                row_bytes = (int'(width_q) + 7) / 8;
                span      = (int'(pitch_q) > row_bytes) ? int'(pitch_q) : row_bytes;
                if (byte_idx < row_bytes) begin
                    first = int'(byte_idx) * 8;
                    for (int k = 0; k < 8; k++) begin
                        if (first + k >= int'(width_q)) begin
                            break;
                        end
                        if (it.data_byte[7-k]) begin
                            if (!pack_pixel(left_col + 12'(first + k), cur_y, fg_color, w)) begin
                                abandon();
                                return;
                            end
                            batch.push_back(w);
                        end
                    end
                    stop  = (first + 8 < int'(width_q)) ? first + 8 : int'(width_q);
                    cur_x = left_col + 12'(stop);
                end
                byte_idx = byte_idx + 8'd1;
                if (int'(byte_idx) >= span) begin
                    end_row();
                end
            end

            if (batch.size() > 0) begin
                batch[batch.size()-1].last = 1'b1;
            end
            foreach (batch[i]) begin
                pending_writes.push_back(batch[i]);
            end
        endfunction

        // Compares one accepted output beat with the oldest expected write.
        function void check_write(input t_result got);
            t_result want;
            if (pending_writes.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("unexpected write at %0t: addr %h data %h bytes %0d err %b last %b",
                             $time, got.write_address, got.write_data, got.write_bytes,
                             got.error, got.last);
                end
                return;
            end
            want = pending_writes.pop_front();
            writes_checked++;
            if (want.error) begin
                errors_seen++;
            end
            // The packed compare covers every field at once.
            if (got !== want) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("write mismatch at %0t", $time);
                    $display("  expected addr %h data %h bytes %0d err %b last %b",
                             want.write_address, want.write_data, want.write_bytes,
                             want.error, want.last);
                    $display("  actual   addr %h data %h bytes %0d err %b last %b",
                             got.write_address, got.write_data, got.write_bytes,
                             got.error, got.last);
                end
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [2:0]  i_cfg_index = '0;
    logic [31:0] i_cfg_data = '0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic        i_mode = MODE_START;
    logic [11:0] i_x_left = '0;
    logic [11:0] i_y_top = '0;
    logic [7:0]  i_glyph_width = '0;
    logic [7:0]  i_glyph_height = '0;
    logic [7:0]  i_row_pitch = '0;
    logic        i_glyph_eight_bit = 1'b0;
    logic [7:0]  i_data_byte = '0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [31:0] o_write_address;
    logic [31:0] o_write_data;
    logic [2:0]  o_write_bytes;
    logic        o_error;
    logic        o_last;

    glyph_scoreboard board;
    bit              calm = 1'b0;
    int              beats_sent = 0;

    glyph_bitmap_blitter dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_valid           (i_valid),
        .o_stall           (o_stall),
        .i_mode            (i_mode),
        .i_x_left          (i_x_left),
        .i_y_top           (i_y_top),
        .i_glyph_width     (i_glyph_width),
        .i_glyph_height    (i_glyph_height),
        .i_row_pitch       (i_row_pitch),
        .i_glyph_eight_bit (i_glyph_eight_bit),
        .i_data_byte       (i_data_byte),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_write_address   (o_write_address),
        .o_write_data      (o_write_data),
        .o_write_bytes     (o_write_bytes),
        .o_error           (o_error),
        .o_last            (o_last)
    );

    always #4 i_clk = ~i_clk;

    // Output side: check each taken beat, then pick the next stall.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            board.check_write({o_write_address, o_write_data, o_write_bytes, o_error, o_last});
        end
        i_stall <= !calm && ($urandom_range(99) < 30);
    end

    function automatic logic [7:0] pick_byte();
        case ($urandom_range(9))
            0:       return 8'h00;
            1:       return 8'hff;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    function automatic t_item start_item(input logic [11:0] x, input logic [11:0] y,
                                         input logic [7:0] w, input logic [7:0] h,
                                         input logic [7:0] pitch, input logic eight);
        t_item it;
        it.mode            = MODE_START;
        it.x_left          = x;
        it.y_top           = y;
        it.glyph_width     = w;
        it.glyph_height    = h;
        it.row_pitch       = pitch;
        it.glyph_eight_bit = eight;
        it.data_byte       = 8'($urandom_range(255));
        return it;
    endfunction

    // Glyph fields on a data beat are don't-care, so they carry noise.
    function automatic t_item data_item(input logic [7:0] b);
        t_item it;
        it.mode            = MODE_DATA;
        it.x_left          = 12'($urandom_range(4095));
        it.y_top           = 12'($urandom_range(4095));
        it.glyph_width     = 8'($urandom_range(255));
        it.glyph_height    = 8'($urandom_range(255));
        it.row_pitch       = 8'($urandom_range(255));
        it.glyph_eight_bit = 1'($urandom_range(1));
        it.data_byte       = b;
        return it;
    endfunction

    // Presents one beat, holds it until taken, and hands it to the scoreboard.
    // Called just after a rising edge.
    task automatic send_beat(input t_item it);
        while (!calm && $urandom_range(99) < 30) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid           <= 1'b1;
        i_mode            <= it.mode;
        i_x_left          <= it.x_left;
        i_y_top           <= it.y_top;
        i_glyph_width     <= it.glyph_width;
        i_glyph_height    <= it.glyph_height;
        i_row_pitch       <= it.row_pitch;
        i_glyph_eight_bit <= it.glyph_eight_bit;
        i_data_byte       <= it.data_byte;
        @(posedge i_clk);
        while (o_stall) begin
            @(posedge i_clk);
        end
        board.note_beat(it);
        beats_sent++;
    endtask

    // Upper data bits of the narrow registers carry noise; the block drops them.
    task automatic write_reg(input logic [2:0] index, input logic [31:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= value;
        @(posedge i_clk);
        board.set_reg(index, value);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_view(input logic [31:0] base, input logic [15:0] line,
                            input logic [1:0] fmt, input logic [23:0] fg,
                            input logic [23:0] bg);
        write_reg(CFG_FRAME_BASE, base);
        write_reg(CFG_LINE_BYTES, {16'($urandom), line});
        write_reg(CFG_PIXEL_FMT, {30'($urandom), fmt});
        write_reg(CFG_FOREGROUND, {8'($urandom), fg});
        write_reg(CFG_BACKGROUND, {8'($urandom), bg});
    endtask

    // Waits until every expected write is out, then lets silent beats settle.
    task automatic drain();
        i_valid <= 1'b0;
        while (board.pending_writes.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (16) @(posedge i_clk);
    endtask

    // Sends one glyph: a start beat and its bitmap, possibly cut short.
    task automatic send_glyph(input bit eight, input int w, input int h, input int pitch,
                              input bit cut, output int beats);
        int span;
        int total;
        span  = eight ? 1 : (((pitch > (w + 7) / 8)) ? pitch : (w + 7) / 8);
        total = (w == 0 || h == 0) ? 0 : (eight ? w * h : h * span);
        if (cut) begin
            total = $urandom_range((total < 6) ? total : 6);
        end
        send_beat(start_item(12'($urandom_range(4095)), 12'($urandom_range(4095)),
                             8'(w), 8'(h), 8'(pitch), eight));
        for (int i = 0; i < total; i++) begin
            send_beat(data_item(pick_byte()));
        end
        beats = total + 1;
    endtask

    // Random glyphs, mostly complete, some cut short, some empty or huge.
    task automatic run_glyphs(input int quota);
        int done;
        int beats;
        bit eight;
        bit cut;
        int w;
        int h;
        int pitch;
        done = 0;
        // These continue a glyph left open by the previous setup, if any.
        repeat (2) send_beat(data_item(pick_byte()));
        while (done < quota) begin
            eight = ($urandom_range(2) == 0);
            cut   = ($urandom_range(9) == 0);
            if ($urandom_range(19) == 0) begin
                w     = $urandom_range(255);
                h     = $urandom_range(255);
                pitch = $urandom_range(255);
                cut   = 1'b1;
            end else if (eight) begin
                w     = $urandom_range(5, 1);
                h     = $urandom_range(3, 1);
                pitch = $urandom_range(255);
            end else begin
                w     = $urandom_range(20, 1);
                h     = $urandom_range(3, 1);
                pitch = $urandom_range(4);
            end
            if ($urandom_range(19) == 0) begin
                if ($urandom_range(1)) begin
                    w = 0;
                end else begin
                    h = 0;
                end
            end
            send_glyph(eight, w, h, pitch, cut, beats);
            done += beats;
            if ($urandom_range(9) == 0) begin
                send_beat(data_item(pick_byte()));
            end
        end
    endtask

    initial begin
        board = new();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed glyphs on a 32 bpp framebuffer.
        set_view(32'h1000_0000, 16'd640, PIX_32BPP, 24'h123456, 24'habcdef);
        // A data beat with no glyph open is dropped.
        send_beat(data_item(8'hff));
        // One-bit glyph wrapping both coordinates, with bits past the width
        // and a padding byte in each row.
        send_beat(start_item(12'd4093, 12'd4095, 8'd10, 8'd2, 8'd3, 1'b0));
        send_beat(data_item(8'hff));
        send_beat(data_item(8'hff));
        send_beat(data_item(8'hff));
        send_beat(data_item(8'h00));
        send_beat(data_item(8'h41));
        send_beat(data_item(8'h00));
        // Zero width leaves no glyph open.
        send_beat(start_item(12'd5, 12'd5, 8'd0, 8'd5, 8'd1, 1'b0));
        send_beat(data_item(8'hff));
        // Eight-bit glyph: background then foreground.
        send_beat(start_item(12'd0, 12'd0, 8'd2, 8'd1, 8'd255, 1'b1));
        send_beat(data_item(8'h00));
        send_beat(data_item(8'h01));
        // Zero pitch still takes two bytes for a nine-pixel row.
        send_beat(start_item(12'd100, 12'd7, 8'd9, 8'd1, 8'd0, 1'b0));
        send_beat(data_item(8'h80));
        send_beat(data_item(8'h80));
        // Largest glyph, full bytes of eight writes each.
        send_beat(start_item(12'd4095, 12'd4095, 8'd255, 8'd255, 8'd255, 1'b0));
        send_beat(data_item(8'hff));
        send_beat(data_item(8'hff));
        drain();

        // No idling at all in the first random stretch.
        calm = 1'b1;
        set_view(32'($urandom), 16'($urandom), PIX_32BPP, 24'($urandom), 24'($urandom));
        run_glyphs(18);
        drain();
        calm = 1'b0;

        set_view(32'hffff_ffff, 16'hffff, PIX_RGB565, 24'hffffff, 24'h000000);
        run_glyphs(18);
        drain();

        set_view(32'h0000_0000, 16'($urandom), PIX_8BPP, 24'h000000, 24'hffffff);
        run_glyphs(18);
        drain();

        // Unsupported depth: an empty one-bit byte passes, the next one fails.
        set_view(32'($urandom), 16'($urandom), PIX_BAD, 24'($urandom), 24'($urandom));
        send_beat(start_item(12'd10, 12'd20, 8'd8, 8'd2, 8'd1, 1'b0));
        send_beat(data_item(8'h00));
        send_beat(data_item(8'h01));
        send_beat(data_item(8'hff));
        send_beat(start_item(12'd30, 12'd40, 8'd3, 8'd1, 8'd0, 1'b1));
        send_beat(data_item(8'h00));
        run_glyphs(14);
        drain();

        set_view(32'($urandom), 16'h0000, 2'($urandom_range(2)),
                 24'($urandom), 24'($urandom));
        run_glyphs(18);
        drain();

        board.mismatches += board.pending_writes.size();
        $display("%0d input beats sent, %0d pixel writes checked, %0d of them error beats,",
                 beats_sent, board.writes_checked, board.errors_seen);
        $display("over six framebuffer setups covering 8 bpp, RGB565, 32 bpp and bad depth");
        if (board.mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("%0d failing checks", board.mismatches);
            $display("end of test: mismatches");
        end
        $finish;
    end

    // Watchdog far beyond the slowest legal run.
    initial begin
        #2000000;
        $display("watchdog expired with %0d writes outstanding", board.pending_writes.size());
        $display("end of test: mismatches");
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/gbb_pkg.sv
hw/rtl/gbb_front.sv
hw/rtl/gbb_queue.sv
hw/rtl/gbb_back.sv
hw/rtl/glyph_bitmap_blitter.sv
test/glyph_bitmap_blitter_tb.sv
